// ----- rtl/smv_pkg.sv -----
`default_nettype none

package smv_pkg;

    localparam int ROW_W = 6;
    localparam int VAL_W = 32;
    localparam int ACC_W = 48;
    localparam int LEN_W = 7;

    // input mode codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENTRY  = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // rounding constant: half a Q16.16 LSB, on the Q32.32 product scale
    localparam logic signed [63:0] RND_HALF = 64'sd32768;

    typedef struct packed {
        logic [1:0]              mode;
        logic [ROW_W-1:0]        row_or_position;
        logic [ROW_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]        result_row;
        logic signed [VAL_W-1:0] result_value;
        logic                    last;
    } t_result;

    typedef enum logic {
        CMD_ENTRY,
        CMD_FINISH
    } t_cmd_kind;

    // word handed from the front to the back
    typedef struct packed {
        t_cmd_kind               kind;
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ACC,
        BK_EMIT_RD,
        BK_EMIT_WR
    } t_back_state;

endpackage

`default_nettype wire

// ----- rtl/smv_fifo.sv -----
`default_nettype none

module smv_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

// ----- rtl/smv_front.sv -----
`default_nettype none

module smv_front #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [smv_pkg::LEN_W-1:0]   i_vec_len,
    input  wire logic                        i_push,
    input  wire smv_pkg::t_item              i_item,
    output logic                             o_full,
    output logic                             o_cmd_push,
    output smv_pkg::t_cmd                    o_cmd,
    input  wire logic                        i_cmd_full
);

    import smv_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [LEN_W-1:0] MaxDimLen = LEN_W'(MAX_DIM);

    logic [VAL_W-1:0]        r_vec_mem [MAX_DIM];
    logic [VAL_W-1:0]        r_vec_q;
    logic                    r_s1_vld;
    t_cmd_kind               r_s1_kind;
    logic [ROW_W-1:0]        r_s1_row;
    logic signed [VAL_W-1:0] r_s1_a;
    logic                    r_s1_col_ok;

    logic [LEN_W-1:0] w_eff_len;
    logic             w_accept;
    logic             w_pos_ok;
    logic             w_col_ok;
    logic             w_row_ok;
    logic             w_load;
    logic             w_entry;
    logic             w_finish;

    // lengths above the store depth act as the full depth
    assign w_eff_len = (i_vec_len > MaxDimLen) ? MaxDimLen : i_vec_len;
    assign w_pos_ok  = ({1'b0, i_item.row_or_position} < w_eff_len);
    assign w_col_ok  = ({1'b0, i_item.column} < w_eff_len);
    assign w_row_ok  = ({1'b0, i_item.row_or_position} < MaxDimLen);

    assign o_full     = r_s1_vld && i_cmd_full;
    assign w_accept   = i_push && !o_full;
    assign o_cmd_push = r_s1_vld && !i_cmd_full;

    always_comb begin
        w_load   = 1'b0;
        w_entry  = 1'b0;
        w_finish = 1'b0;
        unique case (i_item.mode)
            MODE_LOAD:   w_load   = w_accept && w_pos_ok;
            MODE_ENTRY:  w_entry  = w_accept && w_row_ok;
            MODE_FINISH: w_finish = w_accept;
            default: ;  // unused code: drop
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_entry || w_finish) begin
            r_s1_vld <= 1'b1;
        end else if (o_cmd_push) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_entry || w_finish) begin
            r_s1_kind   <= w_entry ? CMD_ENTRY : CMD_FINISH;
            r_s1_row    <= i_item.row_or_position;
            r_s1_a      <= i_item.value;
            r_s1_col_ok <= w_col_ok;
        end
    end

    // vector store: written by loads, read by entries, both in arrival order
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_vec_mem[i_item.row_or_position[IW-1:0]] <= i_item.value;
        end
        if (w_entry) begin
            r_vec_q <= r_vec_mem[i_item.column[IW-1:0]];
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_s1_kind;
        o_cmd.row  = r_s1_row;
        o_cmd.a    = r_s1_a;
        o_cmd.b    = r_s1_col_ok ? $signed(r_vec_q) : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/smv_back.sv -----
`default_nettype none

module smv_back #(
    parameter int MAX_DIM = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire smv_pkg::t_cmd    i_cmd,
    input  wire logic             i_cmd_empty,
    output logic                  o_cmd_pop,
    output logic                  o_res_push,
    output smv_pkg::t_result      o_res,
    input  wire logic             i_res_full
);

    import smv_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic signed [ACC_W-1:0] AccMax = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] AccMin = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] OutMax = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] OutMin = {1'b1, {(VAL_W-1){1'b0}}};

    t_back_state             r_state;
    t_back_state             n_state;
    logic [ACC_W-1:0]        r_rs_mem [MAX_DIM];
    logic [ACC_W-1:0]        r_rs_q;
    logic                    r_rs_hit;
    logic [MAX_DIM-1:0]      r_rs_vld;
    logic [IW-1:0]           r_highest;
    logic [IW-1:0]           r_row;
    logic [IW-1:0]           r_idx;
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_rnd;

    logic signed [63:0]      w_prod;
    logic signed [63:0]      w_rnd;
    logic signed [ACC_W-1:0] w_old;
    logic signed [ACC_W:0]   w_sum;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_rs_re;
    logic [IW-1:0]           w_rs_addr;
    logic                    w_acc_we;
    logic                    w_clear;
    logic                    w_last;
    logic                    w_take;

    assign w_take = !i_cmd_empty;
    assign w_prod = $signed(i_cmd.a) * $signed(i_cmd.b);
    // round half up, then floor shift back to Q16.16
    assign w_rnd  = (r_prod + RND_HALF) >>> 16;
    assign w_old  = r_rs_hit ? $signed(r_rs_q) : '0;
    assign w_sum  = {w_old[ACC_W-1], w_old} + {r_rnd[ACC_W-1], r_rnd};
    assign w_acc  = (w_sum[ACC_W] != w_sum[ACC_W-1]) ?
                    (w_sum[ACC_W] ? AccMin : AccMax) : w_sum[ACC_W-1:0];
    assign w_last = (r_idx == r_highest);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    n_state = (i_cmd.kind == CMD_ENTRY) ? BK_MUL : BK_EMIT_RD;
                end
            end
            BK_MUL:     n_state = BK_ACC;
            BK_ACC:     n_state = BK_IDLE;
            BK_EMIT_RD: n_state = i_res_full ? BK_EMIT_RD : BK_EMIT_WR;
            BK_EMIT_WR: n_state = w_last ? BK_IDLE : BK_EMIT_RD;
            default:    n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        w_rs_re    = 1'b0;
        w_rs_addr  = r_idx;
        w_acc_we   = 1'b0;
        o_res_push = 1'b0;
        w_clear    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_cmd_pop = w_take;
                w_rs_re   = w_take && (i_cmd.kind == CMD_ENTRY);
                w_rs_addr = i_cmd.row[IW-1:0];
            end
            BK_MUL: ;
            BK_ACC:     w_acc_we = 1'b1;
            BK_EMIT_RD: w_rs_re  = !i_res_full;
            BK_EMIT_WR: begin
                o_res_push = 1'b1;
                w_clear    = w_last;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.result_row = ROW_W'(r_idx);
        o_res.last       = w_last;
        // saturate the 48-bit sum to 32 bits
        if (&r_rs_q[ACC_W-1:VAL_W-1] || !(|r_rs_q[ACC_W-1:VAL_W-1]) || !r_rs_hit) begin
            o_res.result_value = r_rs_hit ? $signed(r_rs_q[VAL_W-1:0]) : '0;
        end else begin
            o_res.result_value = r_rs_q[ACC_W-1] ? OutMin : OutMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_rs_vld  <= '0;
            r_highest <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc_we) begin
                r_rs_vld[r_row] <= 1'b1;
                if (r_row > r_highest) begin
                    r_highest <= r_row;
                end
            end
            if (w_clear) begin
                r_rs_vld  <= '0;
                r_highest <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE) begin
            r_prod <= w_prod;
            r_row  <= i_cmd.row[IW-1:0];
            r_idx  <= '0;
        end
        if (r_state == BK_MUL) begin
            r_rnd <= w_rnd[ACC_W-1:0];
        end
        if (r_state == BK_EMIT_WR && !w_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // row sums: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_rs_mem[r_row] <= w_acc;
        end
        if (w_rs_re) begin
            r_rs_q   <= r_rs_mem[w_rs_addr];
            r_rs_hit <= r_rs_vld[w_rs_addr];
        end
    end

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result word pushed into a full queue");

    a_cmd_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !i_cmd_empty)
        else $error("command popped from an empty queue");

    a_highest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_highest) < MAX_DIM)
        else $error("highest row beyond store depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_rs_vld == '0 && r_state == BK_IDLE))
        else $error("accumulators not cleared after final row");

endmodule

`default_nettype wire

// ----- rtl/sparse_matrix_vector_multiply_core.sv -----
// Sparse matrix times dense vector, Q16.16.
// Input queue (push/full): one t_item word per push. Mode 0 loads a vector
// element, mode 1 adds value * vector[column] into a row sum, mode 2 emits
// rows 0 up to the highest row seen and clears all sums. Mode 3 is dropped.
// Output queue (empty/pop): one t_result word per row, last set on the final
// row; sums saturate to 32 bits.
// Configuration: i_cfg_we writes the vector length (i_cfg_wdata) at once;
// write it only while the block is idle.
// Flow: a load is written at acceptance. A matrix entry goes through a
// one-word front stage, a four-word command queue and a multiply, round and
// accumulate sequence (idle, multiply and accumulate states) on the row-sum
// memory, so the back takes a new entry only once the last one is
// accumulated, and the front keeps accepting until the queue fills. A finish
// reads and emits rows in turn (read and write states per row) into a
// four-word result queue, holding while that queue is full.
// A stalled receiver fills the result queue, which halts the back; the
// command queue then fills and full rises. Reset empties both queues, clears
// the row sums and highest row and sets the vector length to 64; vector
// contents are undefined until loaded.
`default_nettype none

module sparse_matrix_vector_multiply_core #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    input  wire smv_pkg::t_item             i_item,
    output logic                            full,
    input  wire logic                       pop,
    output smv_pkg::t_result                o_result,
    output logic                            empty,
    input  wire logic                       i_cfg_we,
    input  wire logic [smv_pkg::LEN_W-1:0]  i_cfg_wdata
);

    import smv_pkg::*;

    localparam int QDEPTH = 4;

    logic [LEN_W-1:0] r_vec_len;
    logic             w_cmd_push;
    t_cmd             w_cmd_in;
    logic             w_cmd_full;
    t_cmd             w_cmd_out;
    logic             w_cmd_empty;
    logic             w_cmd_pop;
    logic             w_res_push;
    t_result          w_res_in;
    logic             w_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len <= 7'd64;
        end else if (i_cfg_we) begin
            r_vec_len <= i_cfg_wdata;
        end
    end

    smv_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vec_len  (r_vec_len),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in),
        .i_cmd_full (w_cmd_full)
    );

    smv_fifo #(.W($bits(t_cmd)), .DEPTH(QDEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    smv_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_full  (w_res_full)
    );

    smv_fifo #(.W($bits(t_result)), .DEPTH(QDEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire
